// File: hw/rtl/blp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit packer package
// Shared widths, payload structs and codes for the LSB-first bit packer.
// ----------------------------------------------------------------------------
package blp_pkg;

  localparam int unsigned PosW        = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned NbitsW      = 6;
  localparam int unsigned DataW       = 8;
  localparam int unsigned MaxCodeBits = 32;
  // Longest code that is taken in; longer bit counts are clamped to this.
  localparam int unsigned CodeLimit   = (MaxCodeBits < ValueW) ? MaxCodeBits : ValueW;
  localparam int unsigned PartialW    = DataW - 1;
  localparam int unsigned PendW       = 3;
  localparam int unsigned AccW        = PartialW + ValueW;
  localparam int unsigned RemW        = 6;

  localparam int unsigned QueueDepthDefault = 2;
  localparam logic [PosW-1:0] CapacityReset = 16'hFFFF;

  typedef enum logic {
    CmdWrite  = 1'b0,
    CmdFinish = 1'b1
  } blp_cmd_e;

  typedef struct packed {
    blp_cmd_e              cmd;
    logic [ValueW-1:0]     value;
    logic [NbitsW-1:0]     nbits;
  } blp_in_t;

  typedef struct packed {
    logic [DataW-1:0]      data_byte;
    logic [PosW-1:0]       byte_position;
    logic                  byte_valid;
    logic [PosW-1:0]       stream_bytes;
    logic                  last;
  } blp_out_t;

  // Queue entry: the value already masked to its bit count, the count clamped.
  typedef struct packed {
    blp_cmd_e              cmd;
    logic [ValueW-1:0]     code;
    logic [NbitsW-1:0]     nbits;
  } blp_entry_t;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } blp_state_e;

endpackage

// File: hw/rtl/blp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit packer front end
// Accepts input items, clamps the bit count and masks the code bits, then
// hands a classified entry to the queue.
// ----------------------------------------------------------------------------
module blp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  blp_pkg::blp_in_t   in_item_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output blp_pkg::blp_entry_t push_entry_o
);
  import blp_pkg::*;

  logic              valid_q, valid_d;
  blp_entry_t        entry_q, entry_d;
  logic [NbitsW-1:0] nbits_clamped;

  assign in_ready_o = !valid_q || push_ready_i;

  always_comb begin
    if (in_item_i.nbits > NbitsW'(CodeLimit)) begin
      nbits_clamped = NbitsW'(CodeLimit);
    end else begin
      nbits_clamped = in_item_i.nbits;
    end
  end

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (push_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d       = 1'b1;
      entry_d.cmd   = in_item_i.cmd;
      entry_d.nbits = nbits_clamped;
      // A shift of the all-ones word by the full width leaves zero, so the
      // mask keeps every bit for a full-width code.
      entry_d.code  = in_item_i.value & ~({ValueW{1'b1}} << nbits_clamped);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

endmodule

// File: hw/rtl/blp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit packer entry queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module blp_queue #(
  parameter int unsigned Depth = blp_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  blp_pkg::blp_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output blp_pkg::blp_entry_t pop_entry_o
);
  import blp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  blp_entry_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: hw/rtl/blp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit packer back end
// Merges codes into the partial byte and emits completed bytes one per cycle
// unless stalled, via an output register; handles flush and capacity limit.
// ----------------------------------------------------------------------------
module blp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [blp_pkg::PosW-1:0]  capacity_i,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  blp_pkg::blp_entry_t       pop_entry_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output blp_pkg::blp_out_t         out_item_o
);
  import blp_pkg::*;

  blp_state_e          state_q, state_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [PartialW-1:0] partial_q, partial_d;
  logic [PendW-1:0]    pending_q, pending_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic                out_valid_q, out_valid_d;
  blp_out_t            out_q, out_d;

  logic                slot_free;
  logic                at_capacity;
  logic [AccW-1:0]     acc_load;
  logic [RemW-1:0]     total_bits;
  logic [RemW-1:0]     rem_after;
  logic [PosW:0]       pos_next;
  logic                cap_hit;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign at_capacity = (pos_q >= capacity_i);
  assign acc_load    = AccW'(partial_q) | (AccW'(pop_entry_i.code) << pending_q);
  assign total_bits  = RemW'(pending_q) + RemW'(pop_entry_i.nbits);
  assign rem_after   = rem_q - RemW'(DataW);
  assign pos_next    = {1'b0, pos_q} + (PosW + 1)'(1);
  assign cap_hit     = (pos_next >= {1'b0, capacity_i});

  assign pop_ready_o = (state_q == StIdle)
                       && ((pop_entry_i.cmd == CmdWrite) || slot_free);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    partial_d   = partial_q;
    pending_d   = pending_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (pop_valid_i && pop_ready_o) begin
          unique case (pop_entry_i.cmd)
            CmdFinish: begin
              out_valid_d        = 1'b1;
              out_d.last         = 1'b1;
              out_d.data_byte    = '0;
              out_d.byte_position = '0;
              out_d.byte_valid   = 1'b0;
              out_d.stream_bytes = pos_q;
              if ((pending_q != '0) && !at_capacity) begin
                out_d.data_byte     = DataW'(partial_q);
                out_d.byte_position = pos_q;
                out_d.byte_valid    = 1'b1;
                out_d.stream_bytes  = pos_next[PosW-1:0];
              end
              partial_d = '0;
              pending_d = '0;
              pos_d     = '0;
            end
            CmdWrite: begin
              // A full stream ignores further bits and keeps its state.
              if (!at_capacity) begin
                if (total_bits < RemW'(DataW)) begin
                  partial_d = acc_load[PartialW-1:0];
                  pending_d = total_bits[PendW-1:0];
                end else begin
                  acc_d   = acc_load;
                  rem_d   = total_bits;
                  state_d = StEmit;
                end
              end
            end
            default: ;
          endcase
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d         = 1'b1;
          out_d.data_byte     = acc_q[DataW-1:0];
          out_d.byte_position = pos_q;
          out_d.byte_valid    = 1'b1;
          out_d.stream_bytes  = '0;
          out_d.last          = cap_hit || (rem_after < RemW'(DataW));
          pos_d               = pos_next[PosW-1:0];
          acc_d               = acc_q >> DataW;
          rem_d               = rem_after;
          if (cap_hit) begin
            // Remaining bits of the code fall beyond the capacity.
            partial_d = '0;
            pending_d = '0;
            state_d   = StIdle;
          end else if (rem_after < RemW'(DataW)) begin
            partial_d = acc_q[DataW +: PartialW];
            pending_d = rem_after[PendW-1:0];
            state_d   = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      partial_q   <= '0;
      pending_q   <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      partial_q   <= partial_d;
      pending_q   <= pending_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hw/rtl/lsb_first_bit_packer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSB-first bit packer
// Packs variable-length codes, bit 0 first, into a byte stream with byte
// positions, stream flush and a capacity limit.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i/in_ready_o, in_item_i) takes write items of
// 0 to 32 code bits and finish items. The output channel (out_valid_o/
// out_ready_i, out_item_o) returns one item per completed byte; a finish
// item always returns exactly one item carrying the flushed byte, if any,
// and the stream byte count. capacity is written through cfg_we_i and
// cfg_wdata_i; the user must do so only while the block is idle, as the
// block itself does not enforce it.
// Path: an item passes the front register and the queue before the back
// end loads it; a finish result then goes to the output register, while a
// write that completes a byte first loads the back-end accumulator and
// then sends its completed bytes through the output register one by one.
// The back end takes no new item until the last byte of a write is out.
// Reset clears the partial byte, the position, the queue and the output
// valid flag, and sets capacity to 65535. When the receiver stalls, the
// output register holds its item, and the back end waits once it has a
// byte or a finish result to pass on; the queue and front register keep
// accepting items until they fill.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_unit #(
  parameter int unsigned QueueDepth = blp_pkg::QueueDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [blp_pkg::PosW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  blp_pkg::blp_in_t         in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output blp_pkg::blp_out_t        out_item_o
);
  import blp_pkg::*;

  logic [PosW-1:0] capacity_q;
  logic            push_valid, push_ready;
  blp_entry_t      push_entry;
  logic            pop_valid, pop_ready;
  blp_entry_t      pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  blp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  blp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  blp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capacity_i  (capacity_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hw/rtl/blp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit packer port checker
// Watches the output channel of the bit packer for consistent result items.
// ----------------------------------------------------------------------------
module blp_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  blp_pkg::blp_out_t out_item_o
);
  import blp_pkg::*;

  // A stalled result item stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item dropped or changed while stalled");

  // Only a flush can return an item without a byte, with zero data and position.
  a_empty_is_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.byte_valid |->
      out_item_o.last && (out_item_o.data_byte == '0)
      && (out_item_o.byte_position == '0))
    else $error("empty result item outside a flush");

  // Items before the last of an input item are plain bytes.
  a_inner_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |->
      out_item_o.byte_valid && (out_item_o.stream_bytes == '0))
    else $error("inner result item carries a count or no byte");

  // A flushed byte is the final byte of its stream.
  a_flush_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.byte_valid && (out_item_o.stream_bytes != '0) |->
      out_item_o.stream_bytes == PosW'(out_item_o.byte_position + PosW'(1)))
    else $error("stream byte count does not follow the flushed byte");

endmodule

bind lsb_first_bit_packer_unit blp_checker u_blp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// File: bench/lsb_first_bit_packer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSB-first bit packer unit test
// Drives write and finish items into the packer, predicts every emitted byte,
// flush and stream count, and compares each output item with the prediction.
// Covers code lengths, clamped bit counts, capacity limits and backpressure.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_unit_test;
  import blp_pkg::*;

  localparam int unsigned SettleCycles = 32;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned LongHold     = 160;
  localparam int unsigned ReportMax    = 10;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [PosW-1:0] cfg_wdata_i;
  logic            in_valid_i;
  logic            in_ready_o;
  blp_in_t         in_item_i;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  blp_out_t        out_item_o;

  lsb_first_bit_packer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the packer state.
  logic [PartialW-1:0] acc_bits;
  logic [PendW-1:0]    acc_count;
  logic [PosW-1:0]     next_pos;
  logic [PosW-1:0]     cap_limit;

  blp_out_t    expected_bytes[$];
  blp_out_t    want_byte;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned cap_writes;
  int unsigned mismatch_count;
  int unsigned error_count;
  int unsigned rx_hold_cycles;
  bit          tx_idle_on;
  bit          rx_idle_on;

  function automatic void push_byte(input blp_out_t res);
    expected_bytes.push_back(res);
  endfunction

  function automatic void pack_item(input blp_in_t item);
    blp_out_t    res;
    blp_out_t    held;
    bit          holding;
    int unsigned n;
    res     = '0;
    held    = '0;
    holding = 1'b0;
    if (item.cmd == CmdFinish) begin
      res.last = 1'b1;
      if (acc_count != 0 && next_pos < cap_limit) begin
        res.byte_valid    = 1'b1;
        res.data_byte     = {1'b0, acc_bits};
        res.byte_position = next_pos;
        next_pos          = next_pos + 1'b1;
      end
      res.stream_bytes = next_pos;
      push_byte(res);
      acc_bits  = '0;
      acc_count = '0;
      next_pos  = '0;
    end else begin
      n = item.nbits;
      if (n > CodeLimit) n = CodeLimit;
      for (int unsigned i = 0; i < n; i++) begin
        if (next_pos >= cap_limit) break;
        if (acc_count == PendW'(DataW - 1)) begin
          // The incoming bit completes a byte; hold it back so that the
          // final byte of this item can still be marked as last.
          if (holding) push_byte(held);
          held               = '0;
          held.data_byte     = {item.value[i], acc_bits};
          held.byte_position = next_pos;
          held.byte_valid    = 1'b1;
          holding            = 1'b1;
          next_pos           = next_pos + 1'b1;
          acc_bits           = '0;
          acc_count          = '0;
        end else begin
          acc_bits[acc_count] = item.value[i];
          acc_count           = acc_count + 1'b1;
        end
      end
      if (holding) begin
        held.last = 1'b1;
        push_byte(held);
      end
    end
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic blp_in_t mk_write(input logic [ValueW-1:0] value,
                                       input logic [NbitsW-1:0] nbits);
    blp_in_t item;
    item.cmd   = CmdWrite;
    item.value = value;
    item.nbits = nbits;
    return item;
  endfunction

  // The payload of a finish item is ignored, so it carries random bits.
  function automatic blp_in_t mk_finish();
    blp_in_t item;
    item.cmd   = CmdFinish;
    item.value = $urandom;
    item.nbits = NbitsW'($urandom_range(0, 63));
    return item;
  endfunction

  function automatic blp_in_t rand_write();
    int unsigned r;
    logic [NbitsW-1:0] nb;
    r = $urandom_range(0, 9);
    if (r == 0)      nb = NbitsW'($urandom_range(33, 63));
    else if (r == 1) nb = NbitsW'(CodeLimit);
    else if (r == 2) nb = '0;
    else             nb = NbitsW'($urandom_range(1, 31));
    return mk_write($urandom, nb);
  endfunction

  task automatic send_item(input blp_in_t item);
    int unsigned gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pack_item(item);
    items_sent++;
  endtask

  // Writes that complete no byte give no result, so the pipeline is given
  // time to settle after the last expected result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [PosW-1:0] cap);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cap_limit = cap;
    cap_writes++;
  endtask

  task automatic test_code_lengths();
    send_item(mk_finish());
    send_item(mk_write(32'hFFFF_FFFF, 6'd0));
    send_item(mk_write(32'h0000_00A5, 6'd8));
    send_item(mk_write(32'hFFFF_FFFF, 6'd32));
    send_item(mk_write(32'h0000_0005, 6'd3));
    send_item(mk_write(32'h1234_5678, 6'd32));
    // Bit counts above the code limit are clamped.
    send_item(mk_write(32'hDEAD_BEEF, 6'd63));
    send_item(mk_write(32'h0000_0000, 6'd33));
    send_item(mk_write(32'h0000_0001, 6'd1));
    send_item(mk_finish());
    send_item(mk_write(32'h0000_007F, 6'd7));
    send_item(mk_finish());
    send_item(mk_write(32'h0000_0000, 6'd32));
    send_item(mk_finish());
    send_item(mk_write(32'hFFFF_0000, 6'd16));
    send_item(mk_write(32'h0F0F_0F0F, 6'd40));
    send_item(mk_finish());
  endtask

  task automatic test_capacity_limits();
    write_capacity('0);
    send_item(mk_write(32'hFFFF_FFFF, 6'd32));
    send_item(mk_finish());
    write_capacity(16'd2);
    send_item(mk_write(32'hFFFF_FFFF, 6'd32));
    send_item(mk_write(32'h0000_00FF, 6'd8));
    send_item(mk_finish());
    write_capacity(16'd1);
    send_item(mk_write(32'h0000_000F, 6'd4));
    send_item(mk_finish());
    // Lower the capacity while bits are still pending in the open stream.
    write_capacity(CapacityReset);
    send_item(mk_write(32'h0000_0ABC, 6'd12));
    write_capacity(16'd1);
    send_item(mk_finish());
  endtask

  task automatic test_random_streams();
    int unsigned sent;
    int unsigned run_len;
    logic [PosW-1:0] cap;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: cap = CapacityReset;
        1: cap = PosW'($urandom_range(4, 24));
        2: cap = PosW'($urandom_range(0, 65535));
        default: cap = 16'd1;
      endcase
      write_capacity(cap);
      tx_idle_on = (phase != 2);
      rx_idle_on = (phase != 2);
      sent = 0;
      while (sent < 30) begin
        run_len = $urandom_range(1, 10);
        repeat (run_len) begin
          send_item(rand_write());
          sent++;
        end
        // Now and then the stream is left open, or an extra empty finish
        // follows the normal one.
        if ($urandom_range(0, 7) != 0) begin
          send_item(mk_finish());
          sent++;
          if ($urandom_range(0, 5) == 0) begin
            send_item(mk_finish());
            sent++;
          end
        end
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    write_capacity(CapacityReset);
    rx_hold_cycles = LongHold;
    repeat (16) send_item(mk_write($urandom, 6'd32));
    send_item(mk_finish());
    wait_idle();
    repeat (4) send_item(rand_write());
    send_item(mk_finish());
  endtask

  always begin
    @(posedge clk_i);
    if (rx_hold_cycles != 0) begin
      out_ready_i <= 1'b0;
      repeat (rx_hold_cycles) @(posedge clk_i);
      rx_hold_cycles = 0;
    end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        error_count++;
        if (mismatch_count <= ReportMax) begin
          $display("unexpected output item: data=%h pos=%0d valid=%b total=%0d last=%b",
                   out_item_o.data_byte, out_item_o.byte_position,
                   out_item_o.byte_valid, out_item_o.stream_bytes, out_item_o.last);
        end
      end else begin
        want_byte = expected_bytes.pop_front();
        if (out_item_o.data_byte !== want_byte.data_byte ||
            out_item_o.byte_position !== want_byte.byte_position ||
            out_item_o.byte_valid !== want_byte.byte_valid ||
            out_item_o.stream_bytes !== want_byte.stream_bytes ||
            out_item_o.last !== want_byte.last) begin
          mismatch_count++;
          error_count++;
          if (mismatch_count <= ReportMax) begin
            $display("mismatch: want data=%h pos=%0d valid=%b total=%0d last=%b",
                     want_byte.data_byte, want_byte.byte_position,
                     want_byte.byte_valid, want_byte.stream_bytes, want_byte.last);
            $display("          got  data=%h pos=%0d valid=%b total=%0d last=%b",
                     out_item_o.data_byte, out_item_o.byte_position,
                     out_item_o.byte_valid, out_item_o.stream_bytes, out_item_o.last);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("lsb_first_bit_packer_unit_test: done, errors");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    acc_bits       = '0;
    acc_count      = '0;
    next_pos       = '0;
    cap_limit      = CapacityReset;
    items_sent     = 0;
    results_seen   = 0;
    cap_writes     = 0;
    mismatch_count = 0;
    error_count    = 0;
    rx_hold_cycles = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_code_lengths();
    test_capacity_limits();
    test_random_streams();
    test_backpressure();
    wait_idle();

    $display("covered %0d input items and %0d output items over %0d capacity writes,",
             items_sent, results_seen, cap_writes);
    $display("including clamped bit counts, saturation and a %0d-cycle output stall",
             LongHold);
    if (error_count == 0) begin
      $display("lsb_first_bit_packer_unit_test: done, clean");
    end else begin
      $display("lsb_first_bit_packer_unit_test: done, errors");
    end
    $finish;
  end

endmodule
